// File: sv/jslm_pkg.sv
// Package for the joint safety limit monitor: widths, codes and reset values.
`timescale 1ns / 1ps

package jslm_pkg;

  localparam int PosW    = 24;
  localparam int VelW    = 24;
  localparam int TempW   = 16;
  localparam int MaxVelW = 23;
  localparam int MarginW = 20;
  localparam int LookW   = 16;
  localparam int CntW    = 5;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 24;
  localparam int InW     = 64;
  localparam int OutW    = 8;

  localparam int ProdW = VelW + LookW + 1;   // velocity times unsigned lookahead
  localparam int PredW = ProdW + 1;          // position*65536 plus product
  localparam int WinW  = PosW + 1;           // limit plus or minus margin

  localparam logic [CntW-1:0]          HEALTH_INTERVAL = 5'd20;
  localparam logic signed [TempW-1:0]  TEMP_LIMIT      = 16'sd850;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_SAFETY_ENABLE    = 3'd0,
    REG_POS_LIMIT_ENABLE = 3'd1,
    REG_VEL_LIMIT_ENABLE = 3'd2,
    REG_POS_LO_LIMIT     = 3'd3,
    REG_POS_HI_LIMIT     = 3'd4,
    REG_SPEED_LIMIT      = 3'd5,
    REG_RECOVERY_MARGIN  = 3'd6,
    REG_LOOKAHEAD        = 3'd7
  } cfg_reg_t;

  // Violation direction codes, two-bit two's complement.
  localparam logic [1:0] DIR_NONE  = 2'b00;
  localparam logic [1:0] DIR_ABOVE = 2'b01;
  localparam logic [1:0] DIR_BELOW = 2'b11;

  localparam logic signed [PosW-1:0] POS_LO_RESET      = -24'sd17991;
  localparam logic signed [PosW-1:0] POS_HI_RESET      = 24'sd17991;
  localparam logic [MaxVelW-1:0]     SPEED_LIMIT_RESET = 23'd17991;
  localparam logic [MarginW-1:0]     MARGIN_RESET      = 20'd286;
  localparam logic [LookW-1:0]       LOOKAHEAD_RESET   = 16'd13107;

endpackage

// File: sv/joint_safety_limit_monitor.sv
// Top level of the joint safety limit monitor: one status report in, one safety word out.
`timescale 1ns / 1ps

// The monitor takes one motor status report per word on the slave stream and
// returns one safety word per report on the master stream, in order. It
// accepts a word in every clock cycle when the output side keeps up. The
// velocity times lookahead product is formed as the report enters the input
// register, and the limit compares, the emergency latch, the health counter
// and the result register are all updated together as the report moves on
// from the input register, so the latch feeds back on itself and never
// holds up the stream. A report can still enter
// while a finished word waits at the output, as long as the input register
// is empty or moving on. Configuration writes are always accepted and are
// meant to be made while no report is in flight; the lookahead register is
// used at input time and the others in the compare stage. Positions are in
// hundredths of a degree, velocities in hundredths of a degree per second,
// temperature in tenths of a degree Celsius and the lookahead in seconds as
// unsigned Q0.16. The predicted position is compared exactly, without any
// rounding. Every twentieth report refreshes the health flag from the
// temperature, which must stay below 85.0 C.
module joint_safety_limit_monitor
  import jslm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // status reports
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InW-1:0]      s_axis_tdata,   // position[23:0], velocity[47:24],
                                              // temperature[63:48]
  // safety words
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutW-1:0]     m_axis_tdata,   // stop_pulse[0], emergency_active[1],
                                              // violation_direction[3:2],
                                              // near_limit_warning[4], recovered[5],
                                              // system_healthy[6], zero[7]
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_data
);

  // Configuration registers.
  logic                      safety_enable;
  logic                      position_limit_enable;
  logic                      velocity_limit_enable;
  logic signed [PosW-1:0]    pos_lo_limit;
  logic signed [PosW-1:0]    pos_hi_limit;
  logic [MaxVelW-1:0]        speed_limit;
  logic [MarginW-1:0]        recovery_margin;
  logic [LookW-1:0]          lookahead_q16;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      safety_enable         <= 1'b1;
      position_limit_enable <= 1'b0;
      velocity_limit_enable <= 1'b0;
      pos_lo_limit          <= POS_LO_RESET;
      pos_hi_limit          <= POS_HI_RESET;
      speed_limit           <= SPEED_LIMIT_RESET;
      recovery_margin       <= MARGIN_RESET;
      lookahead_q16         <= LOOKAHEAD_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SAFETY_ENABLE:    safety_enable         <= cfg_data[0];
        REG_POS_LIMIT_ENABLE: position_limit_enable <= cfg_data[0];
        REG_VEL_LIMIT_ENABLE: velocity_limit_enable <= cfg_data[0];
        REG_POS_LO_LIMIT:     pos_lo_limit          <= cfg_data[PosW-1:0];
        REG_POS_HI_LIMIT:     pos_hi_limit          <= cfg_data[PosW-1:0];
        REG_SPEED_LIMIT:      speed_limit           <= cfg_data[MaxVelW-1:0];
        REG_RECOVERY_MARGIN:  recovery_margin       <= cfg_data[MarginW-1:0];
        REG_LOOKAHEAD:        lookahead_q16         <= cfg_data[LookW-1:0];
        default: ;
      endcase
    end
  end

  // Input register. The product is taken here so that the compare stage
  // holds only adds and compares.
  logic                      in_valid;
  logic signed [PosW-1:0]    in_position;
  logic signed [VelW-1:0]    in_velocity;
  logic signed [TempW-1:0]   in_temperature;
  logic signed [ProdW-1:0]   in_product;
  logic signed [ProdW-1:0]   product_next;
  logic                      advance;

  assign product_next = $signed(s_axis_tdata[PosW +: VelW])
                        * $signed({1'b0, lookahead_q16});

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_position    <= s_axis_tdata[0 +: PosW];
      in_velocity    <= s_axis_tdata[PosW +: VelW];
      in_temperature <= s_axis_tdata[PosW+VelW +: TempW];
      in_product     <= product_next;
    end
  end

  // Monitor state.
  logic             emergency_latch;
  logic [1:0]       direction_store;
  logic [CntW-1:0]  health_counter;
  logic             healthy_flag;

  logic             emergency_latch_next;
  logic [1:0]       direction_store_next;
  logic [CntW-1:0]  health_counter_next;
  logic             healthy_flag_next;

  logic signed [PredW-1:0] predicted;
  logic signed [PredW-1:0] min_scaled;
  logic signed [PredW-1:0] max_scaled;
  logic signed [WinW-1:0]  low_in;
  logic signed [WinW-1:0]  high_in;
  logic signed [WinW-1:0]  pos_ext;
  logic [VelW-1:0]         speed;
  logic                    pos_below;
  logic                    pos_above;
  logic                    vel_over;
  logic                    violation;
  logic [1:0]              dir;
  logic                    inside_window;
  logic                    stop_pulse;
  logic                    near_limit_warning;
  logic                    recovered;
  logic [CntW-1:0]         count_inc;

  // Compare stage: predicted position is kept exact at Q16.
  always_comb begin
    predicted  = $signed({{2{in_position[PosW-1]}}, in_position, 16'b0})
                 + PredW'(in_product);
    min_scaled = $signed({{2{pos_lo_limit[PosW-1]}}, pos_lo_limit, 16'b0});
    max_scaled = $signed({{2{pos_hi_limit[PosW-1]}}, pos_hi_limit, 16'b0});
    low_in     = $signed({pos_lo_limit[PosW-1], pos_lo_limit})
                 + $signed({{(WinW-MarginW){1'b0}}, recovery_margin});
    high_in    = $signed({pos_hi_limit[PosW-1], pos_hi_limit})
                 - $signed({{(WinW-MarginW){1'b0}}, recovery_margin});
    pos_ext    = $signed({in_position[PosW-1], in_position});
    speed      = in_velocity[VelW-1] ? (~in_velocity + 1'b1) : in_velocity;

    pos_below  = position_limit_enable && (predicted < min_scaled);
    pos_above  = position_limit_enable && !pos_below && (predicted > max_scaled);
    vel_over   = velocity_limit_enable && (speed > {1'b0, speed_limit});
    violation  = pos_below || pos_above || vel_over;

    // The speed check wins over the position check for the direction.
    if (vel_over) begin
      dir = in_velocity[VelW-1] ? DIR_BELOW : DIR_ABOVE;
    end else if (pos_below) begin
      dir = DIR_BELOW;
    end else if (pos_above) begin
      dir = DIR_ABOVE;
    end else begin
      dir = DIR_NONE;
    end

    inside_window = (pos_ext > low_in) && (pos_ext < high_in);
  end

  // Next state and result fields.
  always_comb begin
    count_inc            = health_counter + 1'b1;
    health_counter_next  = count_inc;
    healthy_flag_next    = healthy_flag;
    emergency_latch_next = emergency_latch;
    direction_store_next = direction_store;
    stop_pulse           = 1'b0;
    near_limit_warning   = 1'b0;
    recovered            = 1'b0;

    // The temperature refresh comes before the emergency logic, so a new
    // stop on the same report still clears the flag.
    if (count_inc >= HEALTH_INTERVAL) begin
      health_counter_next = '0;
      healthy_flag_next   = (in_temperature < TEMP_LIMIT);
    end

    if (safety_enable) begin
      near_limit_warning = !emergency_latch && position_limit_enable
                           && ((pos_ext <= low_in) || (pos_ext >= high_in));
      if (violation) begin
        if (!emergency_latch) begin
          stop_pulse        = 1'b1;
          healthy_flag_next = 1'b0;
        end
        emergency_latch_next = 1'b1;
        direction_store_next = dir;
      end else if (emergency_latch && inside_window) begin
        emergency_latch_next = 1'b0;
        direction_store_next = DIR_NONE;
        recovered            = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emergency_latch <= 1'b0;
      direction_store <= DIR_NONE;
      health_counter  <= '0;
      healthy_flag    <= 1'b1;
    end else if (advance) begin
      emergency_latch <= emergency_latch_next;
      direction_store <= direction_store_next;
      health_counter  <= health_counter_next;
      healthy_flag    <= healthy_flag_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {1'b0, healthy_flag_next, recovered, near_limit_warning,
                       direction_store_next, emergency_latch_next, stop_pulse};
    end
  end

endmodule
